// File: design/rcb_pkg.sv
// Shared types, constants and a helper function for the address range to CIDR block decomposer.
// No dependencies.
`default_nettype none
package rcb_pkg;

   localparam int ADDR_W            = 32;
   localparam int CNT_W             = 33;
   localparam int PFX_W             = 6;
   localparam int QUEUE_DEPTH_DEF   = 2;

   typedef struct packed {
      logic [ADDR_W-1:0] start_address;
      logic [CNT_W-1:0]  address_count;
      logic              range_error;
   } rcb_item_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } rcb_state_type;

   function automatic logic [PFX_W-1:0] prefix_of(input logic [CNT_W-1:0] blk);
      logic [PFX_W-1:0] k;
      k = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (blk[i]) begin
            k = PFX_W'(i);
         end
      end
      return PFX_W'(ADDR_W) - k;
   endfunction

endpackage
`default_nettype wire

// File: design/rcb_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on rcb_pkg for field widths.
`default_nettype none
interface rcb_req_if import rcb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] start_address;
   logic [CNT_W-1:0]  address_count;

   modport source (output valid, start_address, address_count, input ready);
   modport sink   (input valid, start_address, address_count, output ready);
endinterface

interface rcb_rsp_if import rcb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] block_address;
   logic [PFX_W-1:0]  prefix_length;
   logic              range_error;
   logic              last_block;

   modport source (output valid, block_address, prefix_length, range_error, last_block,
                   input ready);
   modport sink   (input valid, block_address, prefix_length, range_error, last_block,
                   output ready);
endinterface
`default_nettype wire

// File: design/rcb_front.sv
// Front end: accepts requests and classifies each range as valid or in error (empty or past the end).
// Depends on rcb_pkg and rcb_req_if.
`default_nettype none
module rcb_front
   import rcb_pkg::*;
(
   rcb_req_if.sink      req_ch,
   input  logic         q_ready,
   output logic         q_valid,
   output rcb_item_type q_item
);

   logic [CNT_W:0] range_end;

   assign range_end = {1'b0, CNT_W'(req_ch.start_address)} + {1'b0, req_ch.address_count};

   assign req_ch.ready         = q_ready;
   assign q_valid              = req_ch.valid;
   assign q_item.start_address = req_ch.start_address;
   assign q_item.address_count = req_ch.address_count;
   assign q_item.range_error   = (req_ch.address_count == '0) ||
                                 (range_end > (CNT_W+1)'(1) << ADDR_W);

endmodule
`default_nettype wire

// File: design/rcb_queue.sv
// Short queue between the front and back ends.
// Depends on rcb_pkg.
`default_nettype none
module rcb_queue
   import rcb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  rcb_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output rcb_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   rcb_item_type      mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] fill_ff, fill_in;
   logic              push, pop;

   assign push_ready = (fill_ff != CNT_QW'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

// File: design/rcb_back.sv
// Back end: walks one range and emits one aligned CIDR block per cycle while not stalled.
// Depends on rcb_pkg and rcb_rsp_if.
`default_nettype none
module rcb_back
   import rcb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   output logic         q_ready,
   input  rcb_item_type q_item,
   rcb_rsp_if.source    rsp_ch
);

   rcb_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              err_ff, err_in;

   logic              out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic [PFX_W-1:0]  out_pfx_ff, out_pfx_in;
   logic              out_err_ff, out_err_in;
   logic              out_last_ff, out_last_in;

   logic              advance;
   logic [CNT_W-1:0]  cur_ext, low_bit, smear, top_bit, blk;

   assign advance = !out_valid_ff || rsp_ch.ready;
   assign q_ready = (state_ff == S_IDLE);
   assign cur_ext = CNT_W'(cur_ff);

   always_comb begin
      low_bit = cur_ext & (~cur_ext + 1'b1);
      if (cur_ff == '0) begin
         low_bit = CNT_W'(1) << ADDR_W;
      end
      smear = rem_ff;
      for (int s = 1; s < CNT_W; s = s * 2) begin
         smear = smear | (smear >> s);
      end
      top_bit = smear & ~(smear >> 1);
      blk     = (low_bit < top_bit) ? low_bit : top_bit;
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      err_in       = err_ff;
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_pfx_in   = out_pfx_ff;
      out_err_in   = out_err_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cur_in   = q_item.start_address;
               rem_in   = q_item.address_count;
               err_in   = q_item.range_error;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (advance) begin
               out_valid_in = 1'b1;
               if (err_ff) begin
                  out_addr_in = '0;
                  out_pfx_in  = '0;
                  out_err_in  = 1'b1;
                  out_last_in = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  out_addr_in = cur_ff;
                  out_pfx_in  = prefix_of(blk);
                  out_err_in  = 1'b0;
                  out_last_in = (rem_ff == blk);
                  cur_in      = cur_ff + blk[ADDR_W-1:0];
                  rem_in      = rem_ff - blk;
                  if (rem_ff == blk) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rem_ff      <= rem_in;
      err_ff      <= err_in;
      out_addr_ff <= out_addr_in;
      out_pfx_ff  <= out_pfx_in;
      out_err_ff  <= out_err_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.block_address = out_addr_ff;
   assign rsp_ch.prefix_length = out_pfx_ff;
   assign rsp_ch.range_error   = out_err_ff;
   assign rsp_ch.last_block    = out_last_ff;

endmodule
`default_nettype wire

// File: design/address_range_to_cidr_blocks_top.sv
// Address range to CIDR block decomposer, top level.
// Path: a request passes through the queue and the back end's range registers to its output register.
// Throughput: one block per cycle while the response channel is not stalled; the single block
// generator takes no new range until it has emitted the last block of the current one.
// Reset: synchronous, active high; empties the queue and drops any range in progress.
// Depends on rcb_pkg, rcb_if, rcb_front, rcb_queue, rcb_back.
`default_nettype none
module address_range_to_cidr_blocks_top
   import rcb_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   rcb_req_if.sink   req_ch,
   rcb_rsp_if.source rsp_ch
);

   logic         push_valid, push_ready;
   rcb_item_type push_item;
   logic         pop_valid, pop_ready;
   rcb_item_type pop_item;

   rcb_front u_front (
      .req_ch  (req_ch),
      .q_ready (push_ready),
      .q_valid (push_valid),
      .q_item  (push_item)
   );

   rcb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   rcb_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (pop_valid),
      .q_ready (pop_ready),
      .q_item  (pop_item),
      .rsp_ch  (rsp_ch)
   );

endmodule
`default_nettype wire
